// File: rtl/core/lbqs_pkg.sv
// Shared types, constants and helpers for the log-bucket quantile sketch.
// No dependencies; every other file of the block refers to this package by scope.
package lbqs_pkg;

  localparam int BUCKET_SLOTS_DEF = 64;
  localparam int KEY_BITS_DEF     = 12;

  localparam int CNT_W    = 48;
  localparam int WEIGHT_W = 32;
  localparam int Q_W      = 17;
  localparam int RANK_W   = 64;
  localparam int HALF_W   = 24;
  localparam int PROD_W   = Q_W + HALF_W;

  localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(65536);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_APPLY,
    S_Q_PREP,
    S_Q_LO,
    S_Q_HI,
    S_Q_SUM,
    S_Q_WALK
  } state_t;

  // Broadcast controls for the row of bucket cells.
  typedef struct packed {
    logic cmp;
    logic apply;
    logic walk;
    logic any_match;
    logic full;
  } cell_ctl_t;

  // Phase strobes for the rank multiplier.
  typedef struct packed {
    logic prep;
    logic lo;
    logic hi;
    logic sum;
  } rank_ctl_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/core/log_bucket_quantile_sketch.sv
// Top level of the log-bucket quantile sketch: control sequencer, chain of
// bucket cells and rank unit. Uses lbqs_pkg, lbqs_cell and lbqs_rank.
//
// Weighted histogram over signed log-bucket keys, kept as a row of
// BUCKET_SLOTS cells sorted by ascending key. An add (cmd 0) has a compare
// step that checks the key against every cell and an apply step that bumps
// the matching bucket or opens a slot by shifting the larger keys one cell
// right; the apply step waits until the output register can take the result,
// and can accept a new add. An add with a new key while every slot is in use
// is dropped and reports status 1. Counts and the total saturate at 2^48-1.
// A query (cmd 1) has the rank unit form min(quantile,65536)*(total-1) from
// total minus one by low and high partial products and their sum; then a
// running-count token moves one cell per cycle down the whole row and picks
// the first non-negative key whose running count times 65536 exceeds
// the rank. If none qualifies the result is status 2 with key zero. Each
// transaction yields exactly one result; total_count is the total after it.
// The result sits in an output register, so a waiting result does not block
// acceptance of the next transaction until its own result is due.
module log_bucket_quantile_sketch #(
  parameter int BUCKET_SLOTS = lbqs_pkg::BUCKET_SLOTS_DEF,
  parameter int KEY_BITS     = lbqs_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic signed [KEY_BITS-1:0]        bucket_key,
  input  logic [lbqs_pkg::WEIGHT_W-1:0]     weight,
  input  logic [lbqs_pkg::Q_W-1:0]          quantile,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [KEY_BITS-1:0]        result_key,
  output logic [lbqs_pkg::CNT_W-1:0]        total_count
);

  localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
  localparam int WALK_W = $clog2(BUCKET_SLOTS + 1);

  lbqs_pkg::state_t state, state_next;

  logic [FILL_W-1:0]           fill;
  logic [lbqs_pkg::CNT_W-1:0]  observed_total;
  logic [WALK_W-1:0]           walk_cnt;

  // Latched transaction payload
  logic signed [KEY_BITS-1:0]     key_r;
  logic [lbqs_pkg::WEIGHT_W-1:0]  weight_r;
  logic [lbqs_pkg::Q_W-1:0]       q_r;

  lbqs_pkg::cell_ctl_t  ctl;
  lbqs_pkg::rank_ctl_t  rctl;
  logic [lbqs_pkg::RANK_W-1:0] rank;

  logic accept;
  logic can_out;
  logic load_add;
  logic load_query;
  logic walk_last;
  logic any_match;
  logic full;

  // Chain wiring
  logic signed [KEY_BITS-1:0]     key_w   [BUCKET_SLOTS];
  logic [lbqs_pkg::CNT_W-1:0]     count_w [BUCKET_SLOTS];
  logic [BUCKET_SLOTS-1:0]        gt_w;
  logic [BUCKET_SLOTS-1:0]        used_w;
  logic [BUCKET_SLOTS-1:0]        match_w;
  logic [lbqs_pkg::CNT_W-1:0]     trun_w  [BUCKET_SLOTS];
  logic [BUCKET_SLOTS-1:0]        tfound_w;
  logic signed [KEY_BITS-1:0]     tkey_w  [BUCKET_SLOTS];

  assign any_match = |match_w;
  assign full      = (fill == FILL_W'(BUCKET_SLOTS));
  assign can_out   = !out_valid || out_ready;
  assign walk_last = (walk_cnt == WALK_W'(BUCKET_SLOTS));
  assign accept    = in_valid && in_ready;

  // Sequencer: next state and strobes
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    load_add       = 1'b0;
    load_query     = 1'b0;
    ctl            = '0;
    ctl.any_match  = any_match;
    ctl.full       = full;
    rctl           = '0;
    case (state)
      lbqs_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      lbqs_pkg::S_ADD_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = lbqs_pkg::S_ADD_APPLY;
      end
      lbqs_pkg::S_ADD_APPLY: begin
        // hold the update until the output register can take the result
        if (can_out) begin
          ctl.apply  = 1'b1;
          load_add   = 1'b1;
          in_ready   = 1'b1;
          state_next = lbqs_pkg::S_IDLE;
        end
      end
      lbqs_pkg::S_Q_PREP: begin
        rctl.prep  = 1'b1;
        state_next = lbqs_pkg::S_Q_LO;
      end
      lbqs_pkg::S_Q_LO: begin
        rctl.lo    = 1'b1;
        state_next = lbqs_pkg::S_Q_HI;
      end
      lbqs_pkg::S_Q_HI: begin
        rctl.hi    = 1'b1;
        state_next = lbqs_pkg::S_Q_SUM;
      end
      lbqs_pkg::S_Q_SUM: begin
        rctl.sum   = 1'b1;
        state_next = lbqs_pkg::S_Q_WALK;
      end
      lbqs_pkg::S_Q_WALK: begin
        // after the last step the token has crossed every cell; rank is held
        if (walk_last) begin
          if (can_out) begin
            load_query = 1'b1;
            state_next = lbqs_pkg::S_IDLE;
          end
        end else begin
          ctl.walk = 1'b1;
        end
      end
      default: begin
        state_next = lbqs_pkg::S_IDLE;
      end
    endcase
    // a transaction taken here starts on the next cycle
    if (in_valid && in_ready) begin
      state_next = (cmd == lbqs_pkg::CMD_QUERY) ? lbqs_pkg::S_Q_PREP : lbqs_pkg::S_ADD_CMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count, total and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      observed_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (load_add && (any_match || !full)) begin
        observed_total <= lbqs_pkg::sat_add(observed_total, lbqs_pkg::CNT_W'(weight_r));
        if (!any_match) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (load_add || load_query) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk step counter; the first walk cycle is a full token step too
  always_ff @(posedge clk) begin
    if (state != lbqs_pkg::S_Q_WALK) begin
      walk_cnt <= '0;
    end else if (!walk_last) begin
      walk_cnt <= walk_cnt + WALK_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= bucket_key;
      weight_r <= weight;
      q_r      <= (quantile > lbqs_pkg::Q_ONE) ? lbqs_pkg::Q_ONE : quantile;
    end
    if (load_add) begin
      status      <= (any_match || !full) ? lbqs_pkg::ST_OK : lbqs_pkg::ST_FULL;
      result_key  <= '0;
      total_count <= (any_match || !full)
                     ? lbqs_pkg::sat_add(observed_total, lbqs_pkg::CNT_W'(weight_r))
                     : observed_total;
    end else if (load_query) begin
      status      <= tfound_w[BUCKET_SLOTS-1] ? lbqs_pkg::ST_OK : lbqs_pkg::ST_NONE;
      result_key  <= tfound_w[BUCKET_SLOTS-1] ? tkey_w[BUCKET_SLOTS-1] : '0;
      total_count <= observed_total;
    end
  end

  lbqs_rank u_rank (
    .clk   (clk),
    .ctl   (rctl),
    .q_c   (q_r),
    .total (observed_total),
    .rank  (rank)
  );

  for (genvar i = 0; i < BUCKET_SLOTS; i++) begin : g_cell
    logic signed [KEY_BITS-1:0]  l_key;
    logic [lbqs_pkg::CNT_W-1:0]  l_count;
    logic                        l_gt;
    logic                        l_used;
    logic [lbqs_pkg::CNT_W-1:0]  t_run;
    logic                        t_found;
    logic signed [KEY_BITS-1:0]  t_key;

    if (i == 0) begin : g_head
      // head of the row: nothing shifts in, token starts empty
      assign l_key   = '0;
      assign l_count = '0;
      assign l_gt    = 1'b0;
      assign l_used  = 1'b1;
      assign t_run   = '0;
      assign t_found = 1'b0;
      assign t_key   = '0;
    end else begin : g_link
      assign l_key   = key_w[i-1];
      assign l_count = count_w[i-1];
      assign l_gt    = gt_w[i-1];
      assign l_used  = used_w[i-1];
      assign t_run   = trun_w[i-1];
      assign t_found = tfound_w[i-1];
      assign t_key   = tkey_w[i-1];
    end

    lbqs_cell #(
      .KEY_BITS (KEY_BITS),
      .FILL_W   (FILL_W),
      .IDX      (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .in_key       (key_r),
      .in_weight    (weight_r),
      .rank         (rank),
      .fill         (fill),
      .left_key     (l_key),
      .left_count   (l_count),
      .left_gt      (l_gt),
      .left_used    (l_used),
      .tok_in_run   (t_run),
      .tok_in_found (t_found),
      .tok_in_key   (t_key),
      .key          (key_w[i]),
      .count        (count_w[i]),
      .gt           (gt_w[i]),
      .used         (used_w[i]),
      .match        (match_w[i]),
      .tok_run      (trun_w[i]),
      .tok_found    (tfound_w[i]),
      .tok_key      (tkey_w[i])
    );
  end

endmodule

// File: rtl/core/lbqs_cell.sv
// One bucket cell of the sorted chain: key, count, insert/shift logic and one
// stage of the running-count token used by quantile queries. Uses lbqs_pkg.
module lbqs_cell #(
  parameter int KEY_BITS = lbqs_pkg::KEY_BITS_DEF,
  parameter int FILL_W   = 7,
  parameter int IDX      = 0
) (
  input  logic                               clk,
  input  lbqs_pkg::cell_ctl_t                ctl,
  input  logic signed [KEY_BITS-1:0]         in_key,
  input  logic [lbqs_pkg::WEIGHT_W-1:0]      in_weight,
  input  logic [lbqs_pkg::RANK_W-1:0]        rank,
  input  logic [FILL_W-1:0]                  fill,
  input  logic signed [KEY_BITS-1:0]         left_key,
  input  logic [lbqs_pkg::CNT_W-1:0]         left_count,
  input  logic                               left_gt,
  input  logic                               left_used,
  input  logic [lbqs_pkg::CNT_W-1:0]         tok_in_run,
  input  logic                               tok_in_found,
  input  logic signed [KEY_BITS-1:0]         tok_in_key,
  output logic signed [KEY_BITS-1:0]         key,
  output logic [lbqs_pkg::CNT_W-1:0]         count,
  output logic                               gt,
  output logic                               used,
  output logic                               match,
  output logic [lbqs_pkg::CNT_W-1:0]         tok_run,
  output logic                               tok_found,
  output logic signed [KEY_BITS-1:0]         tok_key
);

  logic                        elig;
  logic [lbqs_pkg::CNT_W-1:0]  run_sum;
  logic                        hit;

  assign used = fill > FILL_W'(IDX);

  assign elig    = used && !key[KEY_BITS-1];
  assign run_sum = elig ? lbqs_pkg::sat_add(tok_in_run, count) : tok_in_run;
  assign hit     = elig && ({run_sum, 16'b0} > rank);

  // Compare phase: flag a hit on the key and whether this bucket sorts above it.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= used && (key == in_key);
      gt    <= used && (key > in_key);
    end
  end

  // Apply phase: bump on a hit, else shift right or take the new key.
  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (ctl.any_match) begin
        if (match) begin
          count <= lbqs_pkg::sat_add(count, lbqs_pkg::CNT_W'(in_weight));
        end
      end else if (!ctl.full) begin
        if (left_gt) begin
          key   <= left_key;
          count <= left_count;
        end else if (gt || (!used && left_used)) begin
          key   <= in_key;
          count <= lbqs_pkg::CNT_W'(in_weight);
        end
      end
    end
  end

  // Token stage: carry running count and first hit toward the end of the row.
  always_ff @(posedge clk) begin
    if (ctl.walk) begin
      tok_run   <= run_sum;
      tok_found <= tok_in_found | hit;
      tok_key   <= tok_in_found ? tok_in_key : key;
    end
  end

endmodule

// File: rtl/core/lbqs_rank.sv
// Rank unit: forms quantile * (total - 1) as two 17x24 partial products.
// Uses lbqs_pkg for widths and the phase strobe struct.
module lbqs_rank (
  input  logic                         clk,
  input  lbqs_pkg::rank_ctl_t          ctl,
  input  logic [lbqs_pkg::Q_W-1:0]     q_c,
  input  logic [lbqs_pkg::CNT_W-1:0]   total,
  output logic [lbqs_pkg::RANK_W-1:0]  rank
);

  logic [lbqs_pkg::CNT_W-1:0]  tm1;
  logic [lbqs_pkg::PROD_W-1:0] p_lo;
  logic [lbqs_pkg::PROD_W-1:0] p_hi;

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      // total - 1, clamped at zero
      tm1 <= (total == '0) ? '0 : total - lbqs_pkg::CNT_W'(1);
    end
    if (ctl.lo) begin
      p_lo <= q_c * tm1[lbqs_pkg::HALF_W-1:0];
    end
    if (ctl.hi) begin
      p_hi <= q_c * tm1[lbqs_pkg::CNT_W-1:lbqs_pkg::HALF_W];
    end
    if (ctl.sum) begin
      rank <= lbqs_pkg::RANK_W'({p_hi, {lbqs_pkg::HALF_W{1'b0}}}
                                + (lbqs_pkg::PROD_W + lbqs_pkg::HALF_W)'(p_lo));
    end
  end

endmodule

// File: rtl/core/lbqs_checker.sv
// Port-level checks for the log-bucket quantile sketch, bound to the top level.
// Uses lbqs_pkg for status codes.
module lbqs_checker #(
  parameter int KEY_BITS = lbqs_pkg::KEY_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic signed [KEY_BITS-1:0]    result_key,
  input logic [lbqs_pkg::CNT_W-1:0]    total_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_key)
                                && $stable(total_count))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  // only a successful query carries a key
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lbqs_pkg::ST_OK |-> result_key == '0)
    else $error("nonzero key with failure status");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind log_bucket_quantile_sketch lbqs_checker #(.KEY_BITS(KEY_BITS)) u_lbqs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .result_key  (result_key),
  .total_count (total_count)
);
